// ===== hdl/bm25_pkg.sv =====
package bm25_pkg;

  typedef struct packed {
    logic [15:0] term_count;
    logic [31:0] doc_freq;
    logic [31:0] doc_length;
    logic [15:0] weight;
  } posting_t;

  typedef struct packed {
    logic [31:0] score;
    logic        rejected;
  } result_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1  = 2'd0,
    CFG_B   = 2'd1,
    CFG_N   = 2'd2,
    CFG_AVG = 2'd3
  } cfg_reg_e;

  localparam int K1_W  = 16;
  localparam int B_W   = 13;
  localparam int AVG_W = 32;

  localparam logic [K1_W-1:0]  K1_RESET  = 16'd4915;
  localparam logic [B_W-1:0]   B_RESET   = 13'd3072;
  localparam logic [31:0]      N_RESET   = 32'd0;
  localparam logic [AVG_W-1:0] AVG_RESET = 32'd256;

  localparam logic [B_W-1:0]   B_ONE     = 13'd4096;
  localparam logic [AVG_W-1:0] AVG_ONE   = 32'd256;
  localparam logic [15:0]      BOOST_ONE = 16'd256;

  // log2 unit
  localparam int NORM_W      = 64;
  localparam int LZ_W        = 6;
  localparam int NORM_STAGES = 6;
  localparam int MANT_W      = 31;
  localparam int LOG_FRAC    = 24;
  localparam int LOG_W       = LZ_W + LOG_FRAC;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // length ratio len/avg in Q.12, avg is Q.8
  localparam int RATIO_BITS  = 44;
  localparam int RATIO_SHIFT = 20;
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

  // tf part
  localparam int NRM_W   = 44;
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 61;
  localparam int TF_BITS = 21;

  typedef struct packed {
    logic [NORM_W-1:0] word;
    logic [LZ_W-1:0]   lz;
  } norm_t;

  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic [LOG_W-1:0]  acc;
  } log_t;

endpackage

// ===== hdl/bm25_term_score.sv =====
// throughput: one posting per clock cycle, no gaps
// latency is set by the 44-cell length-ratio divider chain and the 21-cell tf divider
// chain; the 30-cell log2 chain runs beside the first divider
// reset clears the valid pipeline and loads the register defaults; results cannot be stalled
module bm25_term_score import bm25_pkg::*; #(
  parameter int SCORE_FRAC_BITS = 16,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  posting_t              posting_i,
  output result_t               result_o,
  output logic                  result_valid_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW      = COUNT_WIDTH;
  localparam int LW      = CW + 2;
  localparam int IDF_DLY = RATIO_BITS - (NORM_STAGES + LOG_FRAC + 2);
  localparam int LAST    = RATIO_BITS + TF_BITS + 7;
  localparam int LAT     = LAST + 1;
  localparam int RND_SH  = 24 - SCORE_FRAC_BITS;
  localparam logic [44:0] RND_HALF = (45'd1 << RND_SH) >> 1;

  typedef struct packed {
    logic [15:0] tf;
    logic [15:0] boost;
    logic        rej;
    logic        sat;
  } rside_t;

  typedef struct packed {
    logic [LOG_W-1:0] idf;
    logic [15:0]      boost;
    logic             rej;
  } tside_t;

  // configuration registers
  logic [K1_W-1:0]  k1_q;
  logic [B_W-1:0]   b_q;
  logic [31:0]      n_q;
  logic [AVG_W-1:0] avg_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q  <= K1_RESET;
      b_q   <= B_RESET;
      n_q   <= N_RESET;
      avg_q <= AVG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_K1:  k1_q  <= cfg_data_i[K1_W-1:0];
        CFG_B:   b_q   <= cfg_data_i[B_W-1:0];
        CFG_N:   n_q   <= cfg_data_i;
        CFG_AVG: avg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid pipeline
  logic [LAST:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAST-1:0], start && !busy};
    end
  end

  // request capture
  logic [CW-1:0]         df_cw, n_cw, len_cw;
  logic [63:0]           len64;
  logic [AVG_W-1:0]      avg_eff;
  logic [B_W-1:0]        b_eff;
  logic [K1_W-1:0]       k1_eff;
  rside_t                s0_side_d, s0_side_q;
  logic [AVG_W-1:0]      s0_rem_d, s0_rem_q, s0_div_q;
  logic [RATIO_BITS-1:0] s0_bits_d, s0_bits_q;
  logic [LW-1:0]         s0_vn_d, s0_vn_q, s0_vd_d, s0_vd_q;

  always_comb begin
    df_cw   = CW'(posting_i.doc_freq);
    n_cw    = CW'(n_q);
    len_cw  = CW'(posting_i.doc_length);
    if (len_cw == '0) begin
      len_cw = CW'(1);
    end
    len64   = 64'(len_cw);
    avg_eff = (avg_q == '0) ? AVG_ONE : avg_q;
    b_eff   = (b_q > B_ONE) ? B_ONE : b_q;
    k1_eff  = k1_q;

    s0_side_d.tf    = posting_i.term_count;
    s0_side_d.boost = (posting_i.weight == '0) ? BOOST_ONE : posting_i.weight;
    s0_side_d.rej   = (posting_i.term_count == '0) || (df_cw == '0) || (n_cw == '0) ||
                      (df_cw > n_cw);
    // quotient would not fit the Q.12 ratio
    s0_side_d.sat   = (len64[63:RATIO_BITS-1] != '0) ||
                      (len64 >= (64'(avg_eff) << (RATIO_BITS - RATIO_SHIFT)));
    s0_rem_d  = s0_side_d.sat ? '0 : AVG_W'(len64 >> (RATIO_BITS - RATIO_SHIFT));
    s0_bits_d = RATIO_BITS'(len64 << RATIO_SHIFT);

    s0_vn_d = {1'b0, n_cw, 1'b0} + LW'(2);
    s0_vd_d = {1'b0, df_cw, 1'b1};
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= s0_side_d;
    s0_rem_q  <= s0_rem_d;
    s0_div_q  <= avg_eff;
    s0_bits_q <= s0_bits_d;
    s0_vn_q   <= s0_vn_d;
    s0_vd_q   <= s0_vd_d;
  end

  // length ratio divider chain
  logic [AVG_W-1:0]      rd_rem  [0:RATIO_BITS];
  logic [RATIO_BITS-1:0] rd_bits [0:RATIO_BITS];
  logic [AVG_W-1:0]      rd_div  [0:RATIO_BITS];
  rside_t                rd_side [0:RATIO_BITS];

  assign rd_rem[0]  = s0_rem_q;
  assign rd_bits[0] = s0_bits_q;
  assign rd_div[0]  = s0_div_q;
  assign rd_side[0] = s0_side_q;

  for (genvar g = 0; g < RATIO_BITS; g++) begin : g_rdiv
    bm25_div_cell #(
      .DW (AVG_W),
      .BW (RATIO_BITS),
      .SW ($bits(rside_t))
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (rd_rem[g]),
      .bits_i (rd_bits[g]),
      .div_i  (rd_div[g]),
      .side_i (rd_side[g]),
      .rem_o  (rd_rem[g+1]),
      .bits_o (rd_bits[g+1]),
      .div_o  (rd_div[g+1]),
      .side_o (rd_side[g+1])
    );
  end

  // log2 chains for 2N+2 and 2df+1
  norm_t nm_n [0:NORM_STAGES];
  norm_t nm_d [0:NORM_STAGES];
  log_t  lg_n [0:LOG_FRAC];
  log_t  lg_d [0:LOG_FRAC];

  assign nm_n[0] = '{word: NORM_W'(s0_vn_q), lz: '0};
  assign nm_d[0] = '{word: NORM_W'(s0_vd_q), lz: '0};

  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    bm25_norm_cell #(.SH(NORM_W >> (g + 1))) u_n (
      .clk_i (clk_i),
      .st_i  (nm_n[g]),
      .st_o  (nm_n[g+1])
    );
    bm25_norm_cell #(.SH(NORM_W >> (g + 1))) u_d (
      .clk_i (clk_i),
      .st_i  (nm_d[g]),
      .st_o  (nm_d[g+1])
    );
  end

  assign lg_n[0] = '{m:   nm_n[NORM_STAGES].word[NORM_W-1 -: MANT_W],
                     acc: {LZ_W'(NORM_W - 1) - nm_n[NORM_STAGES].lz, LOG_FRAC'(0)}};
  assign lg_d[0] = '{m:   nm_d[NORM_STAGES].word[NORM_W-1 -: MANT_W],
                     acc: {LZ_W'(NORM_W - 1) - nm_d[NORM_STAGES].lz, LOG_FRAC'(0)}};

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
    bm25_log_cell #(.BIT_IDX(LOG_FRAC - 1 - g)) u_n (
      .clk_i (clk_i),
      .st_i  (lg_n[g]),
      .st_o  (lg_n[g+1])
    );
    bm25_log_cell #(.BIT_IDX(LOG_FRAC - 1 - g)) u_d (
      .clk_i (clk_i),
      .st_i  (lg_d[g]),
      .st_o  (lg_d[g+1])
    );
  end

  // idf = (log2 diff) * ln2, then wait for the ratio divider
  logic [LOG_W+31:0] idf_prod_q;
  logic [LOG_W-1:0]  idf_dly_q [0:IDF_DLY];

  always_ff @(posedge clk_i) begin
    idf_prod_q   <= (LOG_W+32)'(lg_n[LOG_FRAC].acc - lg_d[LOG_FRAC].acc) *
                    (LOG_W+32)'(LN2_Q32);
    idf_dly_q[0] <= LOG_W'(((LOG_W+33)'(idf_prod_q) + (LOG_W+33)'(64'd1 << 31)) >> 32);
    for (int j = 1; j <= IDF_DLY; j++) begin
      idf_dly_q[j] <= idf_dly_q[j-1];
    end
  end

  // norm, k1 product, tf divider setup
  logic [RATIO_BITS-1:0] ratio_v;
  logic [B_W+RATIO_BITS:0] nrm_sum;
  logic [NRM_W-1:0]      nrm_q;
  tside_t                nrm_side_q, kn_side_q;
  logic [15:0]           nrm_tf_q, kn_tf_q;
  logic [K1_W+NRM_W-1:0] kn_q;
  logic [NUM_W-1:0]      num_q;
  logic [DEN_W-1:0]      t0_rem_q, t0_den_q;
  tside_t                t0_side_q;

  always_comb begin
    ratio_v = rd_side[RATIO_BITS].sat ? RATIO_MAX : rd_bits[RATIO_BITS];
    nrm_sum = ((B_W+RATIO_BITS+1)'(B_ONE - b_eff) << 12) +
              (B_W+RATIO_BITS+1)'(b_eff) * (B_W+RATIO_BITS+1)'(ratio_v);
  end

  always_ff @(posedge clk_i) begin
    nrm_q            <= NRM_W'(nrm_sum >> 12);
    nrm_tf_q         <= rd_side[RATIO_BITS].tf;
    nrm_side_q.idf   <= idf_dly_q[IDF_DLY];
    nrm_side_q.boost <= rd_side[RATIO_BITS].boost;
    nrm_side_q.rej   <= rd_side[RATIO_BITS].rej;

    kn_q      <= (K1_W+NRM_W)'(k1_eff) * (K1_W+NRM_W)'(nrm_q);
    num_q     <= NUM_W'(nrm_tf_q) * NUM_W'({1'b0, k1_eff} + 17'(B_ONE));
    kn_tf_q   <= nrm_tf_q;
    kn_side_q <= nrm_side_q;

    // dividend is num << 28, its low TF_BITS bits are zero
    t0_den_q  <= DEN_W'(kn_q) + (DEN_W'(kn_tf_q) << 24);
    t0_rem_q  <= DEN_W'(num_q) << (28 - TF_BITS);
    t0_side_q <= kn_side_q;
  end

  // tf part divider chain
  logic [DEN_W-1:0]   td_rem  [0:TF_BITS];
  logic [TF_BITS-1:0] td_bits [0:TF_BITS];
  logic [DEN_W-1:0]   td_div  [0:TF_BITS];
  tside_t             td_side [0:TF_BITS];

  assign td_rem[0]  = t0_rem_q;
  assign td_bits[0] = '0;
  assign td_div[0]  = t0_den_q;
  assign td_side[0] = t0_side_q;

  for (genvar g = 0; g < TF_BITS; g++) begin : g_tdiv
    bm25_div_cell #(
      .DW (DEN_W),
      .BW (TF_BITS),
      .SW ($bits(tside_t))
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (td_rem[g]),
      .bits_i (td_bits[g]),
      .div_i  (td_div[g]),
      .side_i (td_side[g]),
      .rem_o  (td_rem[g+1]),
      .bits_o (td_bits[g+1]),
      .div_o  (td_div[g+1]),
      .side_o (td_side[g+1])
    );
  end

  // idf * tfpart * boost with rounding and saturation
  logic [LOG_W+TF_BITS-1:0] p1_q;
  logic [27:0]              prod_q;
  logic [43:0]              p2_q;
  logic [15:0]              p1_boost_q, prod_boost_q;
  logic                     p1_rej_q, prod_rej_q, p2_rej_q;
  logic [44:0]              sc;
  result_t                  result_d, result_q;

  always_comb begin
    sc = (45'(p2_q) + RND_HALF) >> RND_SH;
    result_d.rejected = p2_rej_q;
    if (p2_rej_q) begin
      result_d.score = '0;
    end else if (sc[44:32] != '0) begin
      result_d.score = '1;
    end else begin
      result_d.score = sc[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q       <= (LOG_W+TF_BITS)'(td_side[TF_BITS].idf) *
                  (LOG_W+TF_BITS)'(td_bits[TF_BITS]);
    p1_boost_q <= td_side[TF_BITS].boost;
    p1_rej_q   <= td_side[TF_BITS].rej;

    prod_q       <= 28'(((LOG_W+TF_BITS+1)'(p1_q) + (LOG_W+TF_BITS+1)'(1 << 23)) >> 24);
    prod_boost_q <= p1_boost_q;
    prod_rej_q   <= p1_rej_q;

    p2_q     <= 44'(prod_q) * 44'(prod_boost_q);
    p2_rej_q <= prod_rej_q;

    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q[LAST];

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT result_valid_o)
    else $error("request did not produce a result at the fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.rejected) |-> (result_o.score == '0))
    else $error("rejected posting carries a nonzero score");

endmodule

// ===== hdl/bm25_norm_cell.sv =====
module bm25_norm_cell import bm25_pkg::*; #(
  parameter int SH = 32
) (
  input  logic  clk_i,
  input  norm_t st_i,
  output norm_t st_o
);

  norm_t st_d, st_q;
  logic  top_zero;

  always_comb begin
    top_zero = (st_i.word[NORM_W-1 -: SH] == '0);
    st_d     = st_i;
    if (top_zero) begin
      st_d.word = st_i.word << SH;
      st_d.lz   = st_i.lz + LZ_W'(SH);
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ===== hdl/bm25_log_cell.sv =====
module bm25_log_cell import bm25_pkg::*; #(
  parameter int BIT_IDX = 23
) (
  input  logic clk_i,
  input  log_t st_i,
  output log_t st_o
);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     top;
  log_t                st_d, st_q;

  always_comb begin
    sq  = (2*MANT_W)'(st_i.m) * (2*MANT_W)'(st_i.m);
    top = sq[2*MANT_W-1:MANT_W-1];
    // square reached [2,4): renormalize and emit a one
    if (top[MANT_W]) begin
      st_d.m = top[MANT_W:1];
    end else begin
      st_d.m = top[MANT_W-1:0];
    end
    st_d.acc = st_i.acc | (LOG_W'(top[MANT_W]) << BIT_IDX);
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ===== hdl/bm25_div_cell.sv =====
module bm25_div_cell #(
  parameter int DW = 32,
  parameter int BW = 44,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic [DW-1:0] rem_i,
  input  logic [BW-1:0] bits_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic [DW-1:0] rem_o,
  output logic [BW-1:0] bits_o,
  output logic [DW-1:0] div_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic [DW-1:0] rem_d, rem_q;
  logic [BW-1:0] bits_d, bits_q;
  logic [DW-1:0] div_q;
  logic [SW-1:0] side_q;

  // one restoring step, quotient bit shifts in where the dividend bit left
  always_comb begin
    trial  = {rem_i, bits_i[BW-1]};
    diff   = trial - {1'b0, div_i};
    take   = (trial >= {1'b0, div_i});
    rem_d  = take ? diff[DW-1:0] : trial[DW-1:0];
    bits_d = {bits_i[BW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    div_q  <= div_i;
    side_q <= side_i;
  end

  assign rem_o  = rem_q;
  assign bits_o = bits_q;
  assign div_o  = div_q;
  assign side_o = side_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import bm25_pkg::*;

  localparam int LATENCY   = 73;
  localparam int WDOG_MAX  = 4000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  posting_t              posting_i;
  result_t               result_o;
  logic                  result_valid_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bm25_term_score u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .posting_i     (posting_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the scoring registers
  logic [15:0] k1_q;
  logic [12:0] b_q;
  logic [31:0] n_q;
  logic [31:0] avg_q;

  result_t score_q[$];
  int      mismatches;
  int      idle_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] log2_q24(logic [63:0] v);
    int          p;
    logic [63:0] m;
    logic [63:0] r;
    if (v == 0) v = 1;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    r = 64'(p) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic result_t bm25_score(posting_t p);
    result_t     res;
    logic [63:0] tf, df, len, boost, avg, b, k1, n;
    logic [63:0] idf, ratio, norm, num, den, tfpart, prod, sc;
    tf    = p.term_count;
    df    = p.doc_freq;
    len   = p.doc_length;
    boost = p.weight;
    n     = n_q;
    avg   = avg_q;
    b     = b_q;
    k1    = k1_q;
    res   = '0;
    if (tf == 0 || df == 0 || n == 0 || df > n) begin
      res.rejected = 1'b1;
      return res;
    end
    if (avg == 0) avg = 256;
    if (boost == 0) boost = 256;
    if (len == 0) len = 1;
    if (b > 4096) b = 4096;
    idf = log2_q24(2 * n + 2) - log2_q24(2 * df + 1);
    idf = (idf * 64'd2977044472 + (64'd1 << 31)) >> 32;
    ratio = (len << 20) / avg;
    if (ratio > 64'hFFF_FFFF_FFFF) ratio = 64'hFFF_FFFF_FFFF;
    norm   = ((4096 - b) * 4096 + b * ratio) >> 12;
    num    = (tf * (k1 + 4096)) << 12;
    den    = (tf << 24) + k1 * norm;
    tfpart = (num << 16) / den;
    prod   = (idf * tfpart + (64'd1 << 23)) >> 24;
    sc     = (prod * boost + (64'd1 << 7)) >> 8;
    if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
    res.score = sc[31:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && result_valid_o) begin
      idle_cycles = 0;
      if (score_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result score=%h rej=%b",
                                       result_o.score, result_o.rejected);
      end else begin
        exp_r = score_q.pop_front();
        if (result_o.score !== exp_r.score || result_o.rejected !== exp_r.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp score=%h rej=%b, got score=%h rej=%b",
                     exp_r.score, exp_r.rejected, result_o.score, result_o.rejected);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_posting(posting_t p);
    @(negedge clk_i);
    start     = 1'b1;
    posting_i = p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    score_q.push_back(bm25_score(p));
    idle_cycles = 0;
  endtask

  task automatic pause_sender();
    int n;
    n = ($urandom_range(0, 9) < 7) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (score_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    idle_cycles = 0;
    case (idx)
      CFG_K1:  k1_q  = val[15:0];
      CFG_B:   b_q   = val[12:0];
      CFG_N:   n_q   = val;
      CFG_AVG: avg_q = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_scoring(logic [15:0] k1, logic [12:0] b, logic [31:0] n,
                             logic [31:0] avg);
    drain();
    write_reg(CFG_K1, 32'(k1));
    write_reg(CFG_B, 32'(b));
    write_reg(CFG_N, n);
    write_reg(CFG_AVG, avg);
  endtask

  function automatic posting_t mk(logic [15:0] tf, logic [31:0] df, logic [31:0] len,
                                  logic [15:0] w);
    posting_t p;
    p.term_count = tf;
    p.doc_freq   = df;
    p.doc_length = len;
    p.weight     = w;
    return p;
  endfunction

  // mostly valid posting with random content, sizes spread over all magnitudes; sel 8 gives raw noise
  function automatic posting_t rand_posting();
    posting_t p;
    int       sel;
    sel = $urandom_range(0, 9);
    p.term_count = (sel < 5) ? 16'($urandom_range(1, 20)) : 16'($urandom);
    if (p.term_count == 0) p.term_count = 1;
    p.doc_freq   = (n_q == 0) ? 32'd1 : 32'($urandom_range(1, n_q));
    p.doc_length = (sel < 3) ? 32'($urandom_range(0, 2000)) : ($urandom >> $urandom_range(0, 31));
    p.weight     = (sel == 9) ? 16'd0 : 16'($urandom);
    if (sel == 8) p = mk(16'($urandom), $urandom, $urandom, 16'($urandom)); // noise
    return p;
  endfunction

  task automatic test_reset_defaults();
    // corpus size resets to zero, so everything is rejected
    send_posting(mk(16'd3, 32'd1, 32'd100, 16'd256));
    send_posting(mk(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
  endtask

  task automatic test_directed();
    set_scoring(16'd4915, 13'd3072, 32'd1000, 32'd25600);
    send_posting(mk(16'd0, 32'd10, 32'd100, 16'd256));   // zero tf
    send_posting(mk(16'd1, 32'd0, 32'd100, 16'd256));    // zero df
    send_posting(mk(16'd1, 32'd1001, 32'd100, 16'd256)); // df above corpus
    send_posting(mk(16'd1, 32'd1000, 32'd100, 16'd256)); // df equal corpus
    send_posting(mk(16'd1, 32'd1, 32'd0, 16'd0));        // zero length and boost
    send_posting(mk(16'hFFFF, 32'd1, 32'hFFFF_FFFF, 16'hFFFF));
    send_posting(mk(16'd5, 32'd7, 32'd100, 16'd512));
    set_scoring(16'hFFFF, 13'h1FFF, 32'hFFFF_FFFF, 32'd0); // b clamps, avg counts as 1.0
    send_posting(mk(16'd1, 32'd1, 32'hFFFF_FFFF, 16'hFFFF));
    send_posting(mk(16'hFFFF, 32'd1, 32'd1, 16'hFFFF));   // saturates
    send_posting(mk(16'd1, 32'hFFFF_FFFF, 32'd1, 16'd1));
    send_posting(mk(16'd2, 32'h8000_0000, 32'd0, 16'h8000));
    set_scoring(16'd0, 13'd0, 32'd1, 32'hFFFF_FFFF);
    send_posting(mk(16'd1, 32'd1, 32'd1, 16'd256));
    send_posting(mk(16'h8000, 32'd1, 32'd12345, 16'h00FF));
    set_scoring(16'd4096, 13'd4096, 32'd50, 32'd1);
    send_posting(mk(16'd3, 32'd2, 32'hFFFF_FFFF, 16'd256)); // huge ratio
    send_posting(mk(16'd3, 32'd49, 32'h0000_1000, 16'd256));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      set_scoring(16'($urandom), 13'($urandom_range(0, 8191)),
                  (phase % 3 == 0) ? 32'($urandom_range(1, 100)) : $urandom,
                  (phase % 4 == 0) ? 32'($urandom_range(0, 4096)) : $urandom);
      for (int i = 0; i < 53; i++) begin
        send_posting(rand_posting());
        if (phase > 2) pause_sender();
      end
      if (phase == 5) drain(); // hold off until everything is back
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    posting_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_K1;
    cfg_data_i  = '0;
    k1_q        = K1_RESET;
    b_q         = B_RESET;
    n_q         = N_RESET;
    avg_q       = AVG_RESET;
    mismatches  = 0;
    idle_cycles = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed();
    test_random();
    drain();
    if (mismatches == 0 && score_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
